>>> design/fda_pkg.sv
// ----------------------------------------------------------------------------
// fda_pkg: shared types for the float to decimal ascii core
// constants, the sequencer states and the job struct passed from the decoder to the formatter
// ----------------------------------------------------------------------------
package fda_pkg;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [3:0] RADIX    = 4'd10;

   // decoded value ready for formatting
   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic [31:0] ipart;
      logic [31:0] fpart;
      logic [3:0]  nfrac;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_INT,
      ST_POINT,
      ST_FRAC
   } state_type;

endpackage

>>> design/fda_ram.sv
// ----------------------------------------------------------------------------
// fda_ram: generic single port write, single port read ram
// read data is registered
// ----------------------------------------------------------------------------
module fda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> design/fda_front.sv
// ----------------------------------------------------------------------------
// fda_front: float decoder
// turns one float word into sign, saturated 32.32 fixed point and digit count
// ----------------------------------------------------------------------------
module fda_front
   import fda_pkg::*;
#(
   parameter int MAX_INT_DIGITS  = 10,
   parameter int MAX_FRAC_DIGITS = 7
) (
   input  logic [31:0] float_bits,
   input  logic [2:0]  frac_digits,
   output job_type     job
);

   localparam longint LIM_RAW = (longint'(10) ** MAX_INT_DIGITS) - 1;
   localparam longint LIM     = (LIM_RAW > 64'd2147483647) ? 64'd2147483647 : LIM_RAW;
   localparam logic [31:0] INT_LIMIT = LIM[31:0];
   localparam logic [3:0]  FRAC_MAX  = 4'(MAX_FRAC_DIGITS);

   logic [7:0]  expo;
   logic [22:0] mant;
   logic        is_nan;
   logic        big;
   logic [63:0] m64;
   logic [63:0] fixed;
   logic [3:0]  nf;

   always_comb begin
      expo   = float_bits[30:23];
      mant   = float_bits[22:0];
      is_nan = (expo == 8'hFF) && (mant != 23'd0);
      big    = (expo >= 8'd158);
      m64    = {40'd0, 1'b1, mant};
      fixed  = 64'd0;
      if (!big && expo != 8'd0) begin
         if (expo >= 8'd118) begin
            fixed = m64 << (expo - 8'd118);
         end else begin
            fixed = m64 >> (8'd118 - expo);
         end
      end
      job.ovf   = big || (fixed[63:32] > INT_LIMIT);
      job.ipart = job.ovf ? INT_LIMIT : fixed[63:32];
      job.fpart = job.ovf ? 32'd0 : fixed[31:0];
      job.neg   = float_bits[31] && !is_nan && (float_bits[30:0] != 31'd0);
      nf        = {1'b0, frac_digits};
      job.nfrac = (nf > FRAC_MAX) ? FRAC_MAX : nf;
   end

endmodule

>>> design/fda_back.sv
// ----------------------------------------------------------------------------
// fda_back: character sequencer
// splits the integer part into digits one per cycle, then streams characters
// ----------------------------------------------------------------------------
module fda_back
   import fda_pkg::*;
#(
   parameter int MAX_INT_DIGITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_take,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_char,
   output logic       out_last,
   output logic       out_ovf
);

   localparam int DW = $clog2(MAX_INT_DIGITS + 1);

   state_type        state_ff, state_in;
   logic [31:0]      quo_ff, quo_in;
   logic [31:0]      frac_ff, frac_in;
   logic [3:0]       digs_ff [MAX_INT_DIGITS];
   logic [DW-1:0]    nd_ff, nd_in;
   logic [3:0]       left_ff, left_in;
   logic             neg_ff, ovf_ff;
   logic [31:0]      q10;
   logic [3:0]       rem;
   logic [35:0]      f10;
   logic             shift_digit;

   // divide by ten through a reciprocal multiply; the remainder comes from multiplying back
   always_comb begin
      logic [63:0] prod;
      logic [35:0] back;
      prod = {32'd0, quo_ff} * 64'hCCCCCCCD;
      q10  = {3'd0, prod[63:35]};
      back = {4'd0, q10} * 36'(RADIX);
      rem  = 4'(36'(quo_ff) - back);
      f10  = {4'd0, frac_ff} * 36'(RADIX);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_DIV;
         ST_DIV:   if (q10 == 32'd0 || 32'(nd_ff) + 32'd1 >= 32'(MAX_INT_DIGITS))
                      state_in = neg_ff ? ST_SIGN : ST_INT;
         ST_SIGN:  if (out_ready) state_in = ST_INT;
         ST_INT:   if (out_ready && nd_ff == DW'(1))
                      state_in = (left_ff != 4'd0) ? ST_POINT : ST_IDLE;
         ST_POINT: if (out_ready) state_in = ST_FRAC;
         ST_FRAC:  if (out_ready && left_ff == 4'd1) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_take    = (state_ff == ST_IDLE) && job_valid;
      shift_digit = (state_ff == ST_DIV);
      out_valid   = 1'b0;
      out_char    = CH_ZERO;
      out_last    = 1'b0;
      out_ovf     = ovf_ff;
      nd_in       = nd_ff;
      left_in     = left_ff;
      quo_in      = quo_ff;
      frac_in     = frac_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               quo_in  = job.ipart;
               frac_in = job.fpart;
               left_in = job.nfrac;
               nd_in   = '0;
            end
         end
         ST_DIV: begin
            quo_in = q10;
            nd_in  = nd_ff + DW'(1);
         end
         ST_SIGN: begin
            out_valid = 1'b1;
            out_char  = CH_MINUS;
         end
         ST_INT: begin
            out_valid = 1'b1;
            out_char  = CH_ZERO + {4'd0, digs_ff[nd_ff - DW'(1)]};
            out_last  = (nd_ff == DW'(1)) && (left_ff == 4'd0);
            if (out_ready) nd_in = nd_ff - DW'(1);
         end
         ST_POINT: begin
            out_valid = 1'b1;
            out_char  = CH_POINT;
         end
         ST_FRAC: begin
            out_valid = 1'b1;
            out_char  = CH_ZERO + {4'd0, f10[35:32]};
            out_last  = (left_ff == 4'd1);
            if (out_ready) begin
               frac_in = f10[31:0];
               left_in = left_ff - 4'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff  <= quo_in;
      frac_ff <= frac_in;
      nd_ff   <= nd_in;
      left_ff <= left_in;
      if (job_take) begin
         neg_ff <= job.neg;
         ovf_ff <= job.ovf;
      end
      if (shift_digit) digs_ff[nd_ff[DW-1:0]] <= rem;
   end

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && out_last |=> state_ff == ST_IDLE)
      else $error("last did not end the text");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |=> state_ff == ST_DIV)
      else $error("job taken outside idle");
   a_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INT |-> nd_ff != '0)
      else $error("no integer digit left");

endmodule

>>> design/float_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// float_to_decimal_ascii_core: float to fixed decimal text
// Push a float word with req_push while req_full is low. Characters come out
// on the rsp_ ports as a queue: read while rsp_empty is low, take with rsp_pop.
// rsp_last marks the final character of a value, rsp_overflow a saturated one.
// csr_ write sets the number of fraction digits; write it only while idle.
// A decoder classifies each word at once into a two-entry queue (ram). The
// sequencer takes a word, splits off its integer digits by a divide by ten,
// and emits one character per cycle while rsp_pop is high.
// A stalled receiver just holds the current character; the queue fills and
// then req_full rises. Reset empties the queue, returns the sequencer to idle
// and clears frac digits to zero.
// ----------------------------------------------------------------------------
module float_to_decimal_ascii_core
   import fda_pkg::*;
#(
   parameter int MAX_INT_DIGITS  = 10,
   parameter int MAX_FRAC_DIGITS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_float_bits,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_character,
   output logic        rsp_last,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_frac_digits
);

   localparam int JW = $bits(job_type);

   logic [2:0] frac_ff;
   job_type    dec_job, q_job;
   logic [1:0] wp_ff, rp_ff, cnt_ff;
   logic       push_ok, take, out_valid;
   logic [JW-1:0] rd_word;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) frac_ff <= 3'd0;
      else if (csr_valid) frac_ff <= csr_frac_digits;
   end

   fda_front #(.MAX_INT_DIGITS(MAX_INT_DIGITS), .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS))
   u_front (.float_bits(req_float_bits), .frac_digits(frac_ff), .job(dec_job));

   // read address leads the pointer so data is ready when count is nonzero
   logic rd_next;
   assign req_full = cnt_ff[1];
   assign push_ok  = req_push && !req_full;

   fda_ram #(.WIDTH(JW), .DEPTH(2)) u_queue (
      .clock(clock), .wr_en(push_ok), .wr_addr(wp_ff[0]), .wr_data(dec_job),
      .rd_addr(rd_next), .rd_data(rd_word));
   assign rd_next = take ? ~rp_ff[0] : rp_ff[0];

   // bypass while the word written this cycle is the one to read next
   logic byp_ff;
   job_type byp_job_ff;
   always_ff @(posedge clock) begin
      byp_ff     <= push_ok && (wp_ff[0] == rd_next);
      byp_job_ff <= dec_job;
   end
   assign q_job = byp_ff ? byp_job_ff : job_type'(rd_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push_ok) wp_ff <= wp_ff + 2'd1;
         if (take) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {1'b0, push_ok} - {1'b0, take};
      end
   end

   fda_back #(.MAX_INT_DIGITS(MAX_INT_DIGITS)) u_back (
      .clock(clock), .reset(reset), .job_valid(cnt_ff != 2'd0), .job(q_job),
      .job_take(take), .out_valid(out_valid), .out_ready(rsp_pop),
      .out_char(rsp_character), .out_last(rsp_last), .out_ovf(rsp_overflow));

   assign rsp_empty = !out_valid;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overrun");
   a_take_has: assert property (@(posedge clock) disable iff (reset)
      take |-> cnt_ff != 2'd0) else $error("take from empty queue");
   a_full: assert property (@(posedge clock) disable iff (reset)
      req_full |=> !(req_push && $past(!take)) || req_full || $past(take))
      else $error("full dropped without a take");

endmodule
